FILE: sv/qvr_pkg.sv
// Shared types, constants and helpers for the quaternion vector rotation block.
package qvr_pkg;

  localparam int QUAT_W = 32;
  localparam int QP_W   = 2 * QUAT_W;
  localparam int RM_W   = QP_W + 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z,
    REG_QUAT_W
  } reg_idx_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  typedef logic signed [QP_W-1:0] qp_t;
  typedef logic signed [RM_W-1:0] rm_t;

  // Width of the row sum: exact R*v plus room for the rounding constant.
  function automatic int acc_width(int vec_w, int frac_bits);
    int exact;
    exact = vec_w + RM_W + 2;
    return (exact > 2 * frac_bits + 1) ? exact : 2 * frac_bits + 1;
  endfunction

  function automatic rm_t sx(qp_t v);
    return {{(RM_W-QP_W){v[QP_W-1]}}, v};
  endfunction

endpackage

FILE: sv/qvr_if.sv
// Stream interfaces for input vectors and rotated results.
interface qvr_in_if #(parameter int VECTOR_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic signed [VECTOR_WIDTH-1:0] vec_x;
  logic signed [VECTOR_WIDTH-1:0] vec_y;
  logic signed [VECTOR_WIDTH-1:0] vec_z;

  modport source (output valid, mode, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, mode, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_out_if #(parameter int VECTOR_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [VECTOR_WIDTH-1:0] out_x;
  logic signed [VECTOR_WIDTH-1:0] out_y;
  logic signed [VECTOR_WIDTH-1:0] out_z;
  logic                           saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: sv/qvr_apb.sv
// APB register file holding the quaternion.
module qvr_apb (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qvr_pkg::ADDR_W-1:0]  paddr,
  input  logic [qvr_pkg::DATA_W-1:0]  pwdata,
  output logic [qvr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output qvr_pkg::quat_t              quat
);
  import qvr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= QUAT_W_RESET;
    end else if (wr) begin
      case (idx)
        REG_QUAT_X: quat.x <= pwdata;
        REG_QUAT_Y: quat.y <= pwdata;
        REG_QUAT_Z: quat.z <= pwdata;
        REG_QUAT_W: quat.w <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUAT_X: prdata = quat.x;
      REG_QUAT_Y: prdata = quat.y;
      REG_QUAT_Z: prdata = quat.z;
      REG_QUAT_W: prdata = quat.w;
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: sv/qvr_matrix.sv
// Two stages: quaternion products, then rotation matrix entries in mode order.
module qvr_matrix #(
  parameter int VECTOR_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic signed [VECTOR_WIDTH-1:0] in_vec [3],
  input  qvr_pkg::quat_t                 quat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output qvr_pkg::rm_t                   out_mat [9],
  output logic signed [VECTOR_WIDTH-1:0] out_vec [3]
);
  import qvr_pkg::*;

  logic a_vld, b_vld, en_a, en_b;
  logic a_mode;
  logic signed [VECTOR_WIDTH-1:0] a_vec [3];
  qp_t a_ww, a_xx, a_yy, a_zz, a_xy, a_xz, a_yz, a_wx, a_wy, a_wz;
  rm_t r [9];
  rm_t sel [9];

  assign en_b      = !b_vld || out_ready;
  assign en_a      = !a_vld || en_b;
  assign in_ready  = en_a;
  assign out_valid = b_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (en_a) a_vld <= in_valid;
      if (en_b) b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_mode <= in_mode;
      a_vec  <= in_vec;
      a_ww   <= quat.w * quat.w;
      a_xx   <= quat.x * quat.x;
      a_yy   <= quat.y * quat.y;
      a_zz   <= quat.z * quat.z;
      a_xy   <= quat.x * quat.y;
      a_xz   <= quat.x * quat.z;
      a_yz   <= quat.y * quat.z;
      a_wx   <= quat.w * quat.x;
      a_wy   <= quat.w * quat.y;
      a_wz   <= quat.w * quat.z;
    end
  end

  always_comb begin
    r[0] = sx(a_ww) + sx(a_xx) - sx(a_yy) - sx(a_zz);
    r[1] = (sx(a_xy) - sx(a_wz)) <<< 1;
    r[2] = (sx(a_xz) + sx(a_wy)) <<< 1;
    r[3] = (sx(a_xy) + sx(a_wz)) <<< 1;
    r[4] = sx(a_ww) - sx(a_xx) + sx(a_yy) - sx(a_zz);
    r[5] = (sx(a_yz) - sx(a_wx)) <<< 1;
    r[6] = (sx(a_xz) - sx(a_wy)) <<< 1;
    r[7] = (sx(a_yz) + sx(a_wx)) <<< 1;
    r[8] = sx(a_ww) - sx(a_xx) - sx(a_yy) + sx(a_zz);
    // inverse rotation uses the transpose
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sel[i*3+j] = a_mode ? r[j*3+i] : r[i*3+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_vld) begin
      out_mat <= sel;
      out_vec <= a_vec;
    end
  end

endmodule

FILE: sv/qvr_mac.sv
// Three stages: split partial products, per-entry products, row sums with rounding.
module qvr_mac #(
  parameter int VECTOR_WIDTH   = 32,
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  qvr_pkg::rm_t                   in_mat [9],
  input  logic signed [VECTOR_WIDTH-1:0] in_vec [3],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [qvr_pkg::acc_width(VECTOR_WIDTH, QUAT_FRAC_BITS)-1:0] out_acc [3]
);
  import qvr_pkg::*;

  localparam int VL     = VECTOR_WIDTH / 2;
  localparam int VH     = VECTOR_WIDTH - VL;
  localparam int RL     = RM_W / 2;
  localparam int RH     = RM_W - RL;
  localparam int PROD_W = RM_W + VECTOR_WIDTH;
  localparam int ACC_W  = acc_width(VECTOR_WIDTH, QUAT_FRAC_BITS);
  localparam logic [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);

  logic c_vld, d_vld, e_vld, en_c, en_d, en_e;

  logic        [RL+VL-1:0]   c_ll [9];
  logic signed [RL+VH:0]     c_lh [9];
  logic signed [RH+VL:0]     c_hl [9];
  logic signed [RH+VH-1:0]   c_hh [9];
  logic signed [PROD_W-1:0]  d_prod [9];

  logic        [RL+VL-1:0]   ll [9];
  logic signed [RL+VH:0]     lh [9];
  logic signed [RH+VL:0]     hl [9];
  logic signed [RH+VH-1:0]   hh [9];
  logic        [PROD_W-1:0]  prod [9];
  logic        [ACC_W-1:0]   acc [3];

  assign en_e      = !e_vld || out_ready;
  assign en_d      = !d_vld || en_e;
  assign en_c      = !c_vld || en_d;
  assign in_ready  = en_c;
  assign out_valid = e_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      if (en_c) c_vld <= in_valid;
      if (en_d) d_vld <= c_vld;
      if (en_e) e_vld <= d_vld;
    end
  end

  // entry i*3+j multiplies vector component j
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      ll[e] = in_mat[e][RL-1:0] * in_vec[e%3][VL-1:0];
      lh[e] = $signed({1'b0, in_mat[e][RL-1:0]}) * $signed(in_vec[e%3][VECTOR_WIDTH-1:VL]);
      hl[e] = $signed(in_mat[e][RM_W-1:RL]) * $signed({1'b0, in_vec[e%3][VL-1:0]});
      hh[e] = $signed(in_mat[e][RM_W-1:RL]) * $signed(in_vec[e%3][VECTOR_WIDTH-1:VL]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && in_valid) begin
      c_ll <= ll;
      c_lh <= lh;
      c_hl <= hl;
      c_hh <= hh;
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      prod[e] = PROD_W'(c_ll[e])
              + (PROD_W'(c_lh[e]) << VL)
              + (PROD_W'(c_hl[e]) << RL)
              + (PROD_W'(c_hh[e]) << (RL + VL));
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_vld) begin
      for (int e = 0; e < 9; e++) d_prod[e] <= prod[e];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(d_prod[i*3]) + ACC_W'(d_prod[i*3+1]) + ACC_W'(d_prod[i*3+2]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e && d_vld) begin
      for (int i = 0; i < 3; i++) out_acc[i] <= acc[i];
    end
  end

endmodule

FILE: sv/qvr_round_sat.sv
// Output stage: drop fraction bits, clamp to the vector width, flag clamping.
module qvr_round_sat #(
  parameter int VECTOR_WIDTH   = 32,
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [qvr_pkg::acc_width(VECTOR_WIDTH, QUAT_FRAC_BITS)-1:0] in_acc [3],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [VECTOR_WIDTH-1:0] out_vec [3],
  output logic                           out_sat
);
  import qvr_pkg::*;

  localparam int ACC_W = acc_width(VECTOR_WIDTH, QUAT_FRAC_BITS);
  localparam logic [VECTOR_WIDTH-1:0] VMAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
  localparam logic [VECTOR_WIDTH-1:0] VMIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

  logic f_vld, en_f;
  logic signed [ACC_W-1:0]        sh [3];
  logic [ACC_W-VECTOR_WIDTH:0]    top [3];
  logic [VECTOR_WIDTH-1:0]        val [3];
  logic [2:0]                     clamp;

  assign en_f      = !f_vld || out_ready;
  assign in_ready  = en_f;
  assign out_valid = f_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en_f) begin
      f_vld <= in_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]    = in_acc[i] >>> (2 * QUAT_FRAC_BITS);
      top[i]   = sh[i][ACC_W-1:VECTOR_WIDTH-1];
      // fits when the bits above the result are all copies of its sign
      clamp[i] = !((&top[i]) || !(|top[i]));
      val[i]   = clamp[i] ? (in_acc[i][ACC_W-1] ? VMIN : VMAX) : sh[i][VECTOR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f && in_valid) begin
      for (int i = 0; i < 3; i++) out_vec[i] <= val[i];
      out_sat <= |clamp;
    end
  end

endmodule

FILE: sv/quaternion_vector_rotation_top.sv
// Top level: APB quaternion registers and the six-stage rotation pipeline.
// Rotates each vector by the quaternion in the registers (mode 0: q*v*conj(q),
// mode 1: conj(q)*v*q), returning saturated Q16.16 components and a clamp flag.
// One vector is accepted every clock unless the pipeline stalls. The stages are:
// quaternion products, matrix entries, split partial products of the
// matrix-vector multiply, per-entry products, row sums with rounding, and the
// clamp and output register. Each stage holds its own valid bit, so a stalled
// output backs up only as far as the bubbles allow. Write the quaternion only
// while no transaction is in flight; q is not normalized, so its squared norm
// also scales the vector.
module quaternion_vector_rotation_top #(
  parameter int VECTOR_WIDTH   = 32,
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qvr_pkg::ADDR_W-1:0]  paddr,
  input  logic [qvr_pkg::DATA_W-1:0]  pwdata,
  output logic [qvr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  qvr_in_if.sink                      in_ch,
  qvr_out_if.source                   out_ch
);
  import qvr_pkg::*;

  localparam int ACC_W = acc_width(VECTOR_WIDTH, QUAT_FRAC_BITS);

  quat_t quat;
  logic  mat_vld, mat_rdy, mac_vld, mac_rdy;
  logic signed [VECTOR_WIDTH-1:0] in_vec  [3];
  logic signed [VECTOR_WIDTH-1:0] mat_vec [3];
  logic signed [VECTOR_WIDTH-1:0] res_vec [3];
  rm_t                            mat     [9];
  logic signed [ACC_W-1:0]        acc     [3];

  assign in_vec[0] = in_ch.vec_x;
  assign in_vec[1] = in_ch.vec_y;
  assign in_vec[2] = in_ch.vec_z;

  qvr_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat    (quat)
  );

  qvr_matrix #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_vec    (in_vec),
    .quat      (quat),
    .out_valid (mat_vld),
    .out_ready (mat_rdy),
    .out_mat   (mat),
    .out_vec   (mat_vec)
  );

  qvr_mac #(
    .VECTOR_WIDTH   (VECTOR_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_vld),
    .in_ready  (mat_rdy),
    .in_mat    (mat),
    .in_vec    (mat_vec),
    .out_valid (mac_vld),
    .out_ready (mac_rdy),
    .out_acc   (acc)
  );

  qvr_round_sat #(
    .VECTOR_WIDTH   (VECTOR_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_vld),
    .in_ready  (mac_rdy),
    .in_acc    (acc),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_vec   (res_vec),
    .out_sat   (out_ch.saturated)
  );

  assign out_ch.out_x = res_vec[0];
  assign out_ch.out_y = res_vec[1];
  assign out_ch.out_z = res_vec[2];

endmodule

FILE: tb/tb_quaternion_vector_rotation_top.sv
// Testbench for the quaternion vector rotation block: APB setup, streamed vectors, result check.
module tb_quaternion_vector_rotation_top;
  import qvr_pkg::*;

  localparam int VEC_W       = 32;
  localparam int FRAC        = 30;
  localparam int SETTLE      = 10;
  localparam int PHASES      = 26;
  localparam int PHASE_ITEMS = 60;
  localparam int MAX_PRINTS  = 60;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
    logic             saturated;
  } rotation_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  qvr_in_if  #(.VECTOR_WIDTH(VEC_W)) vec_in ();
  qvr_out_if #(.VECTOR_WIDTH(VEC_W)) vec_out ();

  quaternion_vector_rotation_top #(
    .VECTOR_WIDTH  (VEC_W),
    .QUAT_FRAC_BITS(FRAC)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (vec_in),
    .out_ch (vec_out)
  );

  quat_t     quat_cfg;
  rotation_t rotated_q[$];
  int        mismatches;
  int        burst_left;
  int        stall_cycle;

  always #2 clk = ~clk;

  task automatic report_mismatch(string line);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, line);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Round half up at 2*FRAC fraction bits, then clamp to the vector width.
  function automatic logic [VEC_W:0] round_clamp(wide_t sum);
    wide_t half;
    wide_t hi_lim;
    wide_t lo_lim;
    wide_t r;
    half = 1;
    half = half <<< (2 * FRAC - 1);
    hi_lim = 1;
    hi_lim = (hi_lim <<< (VEC_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    r = (sum + half) >>> (2 * FRAC);
    if (r > hi_lim) return {1'b1, hi_lim[VEC_W-1:0]};
    if (r < lo_lim) return {1'b1, lo_lim[VEC_W-1:0]};
    return {1'b0, r[VEC_W-1:0]};
  endfunction

  function automatic rotation_t rotate_vector(quat_t q, logic inverse, logic [VEC_W-1:0] vx,
                                              logic [VEC_W-1:0] vy, logic [VEC_W-1:0] vz);
    wide_t            x, y, z, w;
    wide_t            m[9];
    wide_t            v[3];
    wide_t            sum;
    logic [VEC_W:0]   rc;
    logic [VEC_W-1:0] comp[3];
    logic             sat;
    int               e;
    rotation_t        res;
    x = $signed(q.x);
    y = $signed(q.y);
    z = $signed(q.z);
    w = $signed(q.w);
    v[0] = $signed(vx);
    v[1] = $signed(vy);
    v[2] = $signed(vz);
    m[0] = w*w + x*x - y*y - z*z;
    m[1] = 2 * (x*y - w*z);
    m[2] = 2 * (x*z + w*y);
    m[3] = 2 * (x*y + w*z);
    m[4] = w*w - x*x + y*y - z*z;
    m[5] = 2 * (y*z - w*x);
    m[6] = 2 * (x*z - w*y);
    m[7] = 2 * (y*z + w*x);
    m[8] = w*w - x*x - y*y + z*z;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        // inverse rotation uses the transposed matrix
        e = inverse ? j * 3 + i : i * 3 + j;
        sum = sum + m[e] * v[j];
      end
      rc = round_clamp(sum);
      comp[i] = rc[VEC_W-1:0];
      sat = sat | rc[VEC_W];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.saturated = sat;
    return res;
  endfunction

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_QUAT_X: quat_cfg.x = value;
      REG_QUAT_Y: quat_cfg.y = value;
      REG_QUAT_Z: quat_cfg.z = value;
      REG_QUAT_W: quat_cfg.w = value;
      default: ;
    endcase
  endtask

  task automatic apb_read_check(reg_idx_t idx);
    logic [31:0] want;
    case (idx)
      REG_QUAT_X: want = quat_cfg.x;
      REG_QUAT_Y: want = quat_cfg.y;
      REG_QUAT_Z: want = quat_cfg.z;
      default:    want = quat_cfg.w;
    endcase
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field($sformatf("readback %s", idx.name()), prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and wait until the pipeline has drained.
  task automatic wait_idle();
    vec_in.valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_quat(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz, logic [31:0] qw);
    wait_idle();
    apb_write(REG_QUAT_X, qx);
    apb_write(REG_QUAT_Y, qy);
    apb_write(REG_QUAT_Z, qz);
    apb_write(REG_QUAT_W, qw);
    apb_read_check(REG_QUAT_X);
    apb_read_check(REG_QUAT_Y);
    apb_read_check(REG_QUAT_Z);
    apb_read_check(REG_QUAT_W);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_vector(logic mode, logic [VEC_W-1:0] vx, logic [VEC_W-1:0] vy,
                             logic [VEC_W-1:0] vz);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        vec_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    vec_in.valid <= 1'b1;
    vec_in.mode  <= mode;
    vec_in.vec_x <= vx;
    vec_in.vec_y <= vy;
    vec_in.vec_z <= vz;
    do @(posedge clk); while (!vec_in.ready);
    rotated_q.push_back(rotate_vector(quat_cfg, mode, vx, vy, vz));
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_component();
    logic [31:0] r;
    case ($urandom_range(0, 3))
      0, 1: begin
        r = $urandom_range(0, 32'h001f_ffff);
        return r - 32'h0010_0000;
      end
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] random_quat_word(int kind);
    logic [31:0] r;
    case (kind)
      0: begin
        r = $urandom_range(0, 32'h3fff_ffff);
        return r - 32'h2000_0000;
      end
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h4000_0000;
          default: return 32'hc000_0000;
        endcase
      end
      default: begin
        r = $urandom_range(0, 32'h01ff_ffff);
        return r - 32'h0100_0000;
      end
    endcase
  endfunction

  task automatic test_identity_after_reset();
    apb_read_check(REG_QUAT_X);
    apb_read_check(REG_QUAT_Y);
    apb_read_check(REG_QUAT_Z);
    apb_read_check(REG_QUAT_W);
    send_vector(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_vector(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_vector(1'b1, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
    send_vector(1'b0, 32'hffff_0000, 32'h0001_8000, 32'h1234_5678);
    send_vector(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_directed_quaternions();
    // quarter turn about z
    set_quat(32'h0000_0000, 32'h0000_0000, 32'h2d41_3ccd, 32'h2d41_3ccd);
    send_vector(1'b0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(1'b1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(1'b0, 32'h0000_0000, 32'h0002_0000, 32'hffff_0000);
    send_vector(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // zero quaternion: everything collapses to zero without clamping
    set_quat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_vector(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // most negative components: large scale, overflow both ways
    set_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_vector(1'b1, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0000);
    // most positive, non-unit quaternion
    set_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(1'b0, 32'h0000_8000, 32'hffff_8000, 32'h0000_0001);
    send_vector(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    // half-LSB ties land here with a scale of one quarter
    set_quat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h2000_0000);
    send_vector(1'b0, 32'h0000_0002, 32'hffff_fffe, 32'h0000_0006);
    send_vector(1'b1, 32'hffff_fffa, 32'h0000_000a, 32'h8000_0002);
  endtask

  task automatic test_random_stream();
    int kind;
    for (int p = 0; p < PHASES; p++) begin
      kind = (p < 4) ? p : $urandom_range(0, 3);
      if (kind == 3)
        set_quat(random_quat_word(3), random_quat_word(3), random_quat_word(3),
                 $urandom_range(0, 1) ? 32'h4000_0000 : 32'hc000_0000);
      else
        set_quat(random_quat_word(kind), random_quat_word(kind), random_quat_word(kind),
                 random_quat_word(kind));
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_vector($urandom_range(0, 1), random_component(), random_component(),
                    random_component());
    end
  endtask

  // Receiver: steady, light, heavy and periodic stall patterns in turn.
  always @(negedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 300) % 4)
      0: vec_out.ready <= 1'b1;
      1: vec_out.ready <= ($urandom_range(0, 3) != 0);
      2: vec_out.ready <= ($urandom_range(0, 2) == 0);
      default: vec_out.ready <= ((stall_cycle % 16) < 11);
    endcase
  end

  always @(posedge clk) begin
    rotation_t want;
    if (!rst && vec_out.valid && vec_out.ready) begin
      if (rotated_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h %h %h", vec_out.out_x,
                                  vec_out.out_y, vec_out.out_z));
      end else begin
        want = rotated_q.pop_front();
        check_field("out_x", vec_out.out_x, want.x);
        check_field("out_y", vec_out.out_y, want.y);
        check_field("out_z", vec_out.out_z, want.z);
        check_field("saturated", {31'b0, vec_out.saturated}, {31'b0, want.saturated});
      end
    end
  end

  initial begin
    #800000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    vec_in.valid  = 1'b0;
    vec_in.mode   = 1'b0;
    vec_in.vec_x  = '0;
    vec_in.vec_y  = '0;
    vec_in.vec_z  = '0;
    vec_out.ready = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    stall_cycle   = 0;
    quat_cfg      = '{x: '0, y: '0, z: '0, w: QUAT_W_RESET};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_identity_after_reset();
    test_directed_quaternions();
    test_random_stream();
    wait_idle();
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
